// File: rtl/core/lcd_mode_timing_sequencer_macros.svh
// ---------------------------------------------------------------------------
// LCD mode timing sequencer assertion macros
// Shared assertion forms with a reset guard.
// ---------------------------------------------------------------------------
`ifndef LCD_MODE_TIMING_SEQUENCER_MACROS_SVH
`define LCD_MODE_TIMING_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmts assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LMTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmts assertion failed");

`endif

// File: rtl/core/lmts_pkg.sv
// ---------------------------------------------------------------------------
// LCD mode timing sequencer package
// Phase codes, STAT mode codes, line constants, cycle tables and shared types.
// ---------------------------------------------------------------------------
package lmts_pkg;

   typedef enum logic [2:0] {
      PH_OAM    = 3'd0,
      PH_VRAM   = 3'd1,
      PH_HBLANK = 3'd2,
      PH_L90B   = 3'd3,
      PH_L90E   = 3'd4,
      PH_VBLANK = 3'd5
   } lmts_phase_type;

   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   localparam logic [7:0] LINE_VBL_START = 8'h90;
   localparam logic [7:0] LINE_WRAP      = 8'h9a;
   localparam logic [3:0] SPRITE_MAX     = 4'd10;

   localparam logic [9:0] L90_CYCLES    = 10'd24;
   localparam logic [9:0] LINE_CYC_NORM = 10'd456;
   localparam logic [9:0] LINE_CYC_DBL  = 10'd912;
   localparam logic [9:0] OAM_CYC_NORM  = 10'd82;
   localparam logic [9:0] OAM_CYC_DBL   = 10'd164;

   localparam int STAT_EN_HBLANK = 0;
   localparam int STAT_EN_VBLANK = 1;
   localparam int STAT_EN_OAM    = 2;
   localparam int STAT_EN_LYC    = 3;

   typedef struct packed {
      logic [7:0]     scan_line;
      lmts_phase_type phase;
      logic           advance_pending;
      logic [3:0]     sprites;
   } lmts_state_type;

   typedef struct packed {
      logic [7:0] compare_line;
      logic [3:0] stat_int_enables;
      logic [3:0] sprite_count;
      logic       hdma_active;
   } lmts_item_type;

   typedef struct packed {
      logic [9:0] next_duration;
      logic [1:0] stat_mode;
      logic       line_match;
      logic [7:0] current_line;
      logic       stat_int_request;
      logic       vblank_int_request;
      logic       draw_line;
      logic       frame_end;
      logic       hdma_step;
   } lmts_result_type;

   // Normal-speed pixel transfer cycles by sprite count.
   function automatic logic [9:0] xfer_cycles(input logic [3:0] sprites);
      logic [9:0] cyc;
      unique case (sprites)
         4'd0:    cyc = 10'd170;
         4'd1:    cyc = 10'd184;
         4'd2:    cyc = 10'd196;
         4'd3:    cyc = 10'd208;
         4'd4:    cyc = 10'd220;
         4'd5:    cyc = 10'd234;
         4'd6:    cyc = 10'd244;
         4'd7:    cyc = 10'd260;
         4'd8:    cyc = 10'd270;
         4'd9:    cyc = 10'd284;
         default: cyc = 10'd296;
      endcase
      return cyc;
   endfunction

   // Normal-speed hblank cycles by sprite count.
   function automatic logic [9:0] hbl_cycles(input logic [3:0] sprites);
      logic [9:0] cyc;
      unique case (sprites)
         4'd0:    cyc = 10'd204;
         4'd1:    cyc = 10'd190;
         4'd2:    cyc = 10'd178;
         4'd3:    cyc = 10'd166;
         4'd4:    cyc = 10'd154;
         4'd5:    cyc = 10'd140;
         4'd6:    cyc = 10'd130;
         4'd7:    cyc = 10'd114;
         4'd8:    cyc = 10'd104;
         4'd9:    cyc = 10'd90;
         default: cyc = 10'd78;
      endcase
      return cyc;
   endfunction

endpackage

// File: rtl/core/lmts_step.sv
// ---------------------------------------------------------------------------
// LCD mode timing sequencer step logic
// Computes the next sequencer state and the result for one phase-end item.
// ---------------------------------------------------------------------------
module lmts_step
   import lmts_pkg::*;
(
   input  lmts_state_type  state_cur,
   input  lmts_item_type   item,
   input  logic            speed_sel,
   output lmts_state_type  state_nxt,
   output lmts_result_type result
);

   logic [7:0]     line_adv;
   logic [7:0]     line_now;
   lmts_phase_type phase_adv;
   lmts_phase_type phase_now;
   logic           wrap;
   logic           match;
   logic [3:0]     ls;
   logic [3:0]     spr_sat;
   logic [9:0]     line_cyc;
   logic [9:0]     oam_cyc;
   logic [9:0]     xfer_base;
   logic [9:0]     hbl_base;
   logic [9:0]     xfer_cyc;
   logic [9:0]     hbl_cyc;

   function automatic logic [7:0] line_cur_inc(input logic [7:0] line);
      return line + 8'd1;
   endfunction

   always_comb begin
      line_adv  = state_cur.advance_pending ? line_cur_inc(state_cur.scan_line)
                                            : state_cur.scan_line;
      phase_adv = (line_adv == LINE_VBL_START && state_cur.phase == PH_OAM)
                  ? PH_L90B : state_cur.phase;
      wrap      = (line_adv == LINE_WRAP);
      line_now  = wrap ? 8'd0 : line_adv;
      phase_now = wrap ? PH_OAM : phase_adv;
      match     = (item.compare_line == line_now);

      ls       = (state_cur.sprites > SPRITE_MAX) ? SPRITE_MAX : state_cur.sprites;
      spr_sat  = (item.sprite_count > SPRITE_MAX) ? SPRITE_MAX : item.sprite_count;
      line_cyc = speed_sel ? LINE_CYC_DBL : LINE_CYC_NORM;
      oam_cyc  = speed_sel ? OAM_CYC_DBL : OAM_CYC_NORM;
      // Double-speed table entries are exactly twice the normal-speed ones.
      xfer_base = xfer_cycles(ls);
      hbl_base  = hbl_cycles(ls);
      xfer_cyc  = speed_sel ? {xfer_base[8:0], 1'b0} : xfer_base;
      hbl_cyc   = speed_sel ? {hbl_base[8:0], 1'b0} : hbl_base;

      state_nxt           = state_cur;
      state_nxt.scan_line = line_now;
      state_nxt.phase     = phase_now;

      result                    = '0;
      result.line_match         = match;
      result.current_line       = line_now;
      result.frame_end          = wrap;

      unique case (phase_now)
         PH_HBLANK: begin
            result.stat_mode        = MODE_HBLANK;
            result.stat_int_request = item.stat_int_enables[STAT_EN_HBLANK];
            result.draw_line        = 1'b1;
            result.next_duration    = hbl_cyc;
            result.hdma_step        = item.hdma_active;
            state_nxt.phase           = PH_OAM;
            state_nxt.advance_pending = 1'b1;
         end
         PH_L90B: begin
            result.stat_mode        = MODE_VBLANK;
            result.next_duration    = L90_CYCLES;
            result.stat_int_request = item.stat_int_enables[STAT_EN_VBLANK] |
                                      (item.stat_int_enables[STAT_EN_LYC] & match);
            state_nxt.phase           = PH_L90E;
            state_nxt.advance_pending = 1'b0;
         end
         PH_L90E: begin
            result.stat_mode          = MODE_VBLANK;
            result.next_duration      = line_cyc - L90_CYCLES;
            result.vblank_int_request = 1'b1;
            state_nxt.phase           = PH_VBLANK;
            state_nxt.advance_pending = 1'b1;
         end
         PH_VBLANK: begin
            result.stat_mode          = MODE_VBLANK;
            result.next_duration      = line_cyc;
            state_nxt.advance_pending = 1'b1;
         end
         PH_VRAM: begin
            result.stat_mode     = MODE_XFER;
            result.next_duration = xfer_cyc;
            state_nxt.phase      = PH_HBLANK;
         end
         default: begin
            result.stat_mode        = MODE_OAM;
            result.next_duration    = oam_cyc;
            result.stat_int_request = item.stat_int_enables[STAT_EN_OAM] |
                                      (item.stat_int_enables[STAT_EN_LYC] & match);
            state_nxt.phase           = PH_VRAM;
            state_nxt.advance_pending = 1'b0;
            state_nxt.sprites         = spr_sat;
         end
      endcase
   end

endmodule

// File: rtl/core/lcd_mode_timing_sequencer.sv
// ---------------------------------------------------------------------------
// LCD mode timing sequencer
// Steps the display phase and scan line on each phase-end item and reports
// the cycles to the next event together with STAT and interrupt pulses.
// ---------------------------------------------------------------------------
// Each item on the req_ channel is one phase-end event; each produces exactly
// one item on the rsp_ channel. An item is taken when req_valid is high and
// req_stall is low, and delivered when rsp_valid is high and rsp_stall is low.
// An item goes into an input register, passes through the step logic when
// the result register is free or being emptied, and appears in the next cycle.
// Throughput is one item per cycle while the receiver does not stall, set by
// the combinational step logic between the two registers.
// While the receiver stalls, the result holds and the input register still
// takes one more item; req_stall then rises until the result is taken.
// The csr_ channel writes the speed-select bit and is always ready; it must be
// written only while no item is in flight, which the block does not enforce.
// Reset clears both registers' valid flags, puts the sequencer at line 0 in
// the OAM scan phase with no sprites latched, and selects normal speed.
// ---------------------------------------------------------------------------
`include "lcd_mode_timing_sequencer_macros.svh"

module lcd_mode_timing_sequencer
   import lmts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_speed_sel,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_compare_line,
   input  logic [3:0] req_stat_int_enables,
   input  logic [3:0] req_sprite_count,
   input  logic       req_hdma_active,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [9:0] rsp_next_duration,
   output logic [1:0] rsp_stat_mode,
   output logic       rsp_line_match,
   output logic [7:0] rsp_current_line,
   output logic       rsp_stat_int_request,
   output logic       rsp_vblank_int_request,
   output logic       rsp_draw_line,
   output logic       rsp_frame_end,
   output logic       rsp_hdma_step
);

   logic            speed_sel_ff;
   logic            in_valid_ff;
   logic            in_valid_in;
   lmts_item_type   item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   lmts_result_type result_ff;
   lmts_result_type result_in;
   lmts_state_type  state_ff;
   lmts_state_type  state_in;
   logic            advance;
   logic            req_take;

   assign csr_ready = 1'b1;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   lmts_step u_step (
      .state_cur    (state_ff),
      .item         (item_ff),
      .speed_sel    (speed_sel_ff),
      .state_nxt    (state_in),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_sel_ff    <= 1'b0;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff        <= '{scan_line: 8'd0, phase: PH_OAM,
                              advance_pending: 1'b0, sprites: 4'd0};
      end else begin
         if (csr_valid && csr_ready) begin
            speed_sel_ff <= csr_speed_sel;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= '{compare_line: req_compare_line,
                      stat_int_enables: req_stat_int_enables,
                      sprite_count: req_sprite_count,
                      hdma_active: req_hdma_active};
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_next_duration      = result_ff.next_duration;
   assign rsp_stat_mode          = result_ff.stat_mode;
   assign rsp_line_match         = result_ff.line_match;
   assign rsp_current_line       = result_ff.current_line;
   assign rsp_stat_int_request   = result_ff.stat_int_request;
   assign rsp_vblank_int_request = result_ff.vblank_int_request;
   assign rsp_draw_line          = result_ff.draw_line;
   assign rsp_frame_end          = result_ff.frame_end;
   assign rsp_hdma_step          = result_ff.hdma_step;

   `LMTS_ASSERT_NEXT(a_advance_fills_output, clock, reset, advance, rsp_valid)
   `LMTS_ASSERT_SAME(a_frame_end_line_zero, clock, reset, rsp_valid && rsp_frame_end,
                     rsp_current_line == 8'd0)
   `LMTS_ASSERT_SAME(a_vblank_int_mode, clock, reset, rsp_valid && rsp_vblank_int_request,
                     rsp_stat_mode == MODE_VBLANK)
   `LMTS_ASSERT_SAME(a_draw_in_hblank, clock, reset, rsp_valid && rsp_draw_line,
                     rsp_stat_mode == MODE_HBLANK)

endmodule
